// ===== hw/rtl/sske_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the sparse SVM kernel evaluator.
package sske_pkg;

    localparam int VECTOR_DEPTH_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Restoring divider: dividend and divisor widths.
    localparam int DIV_W = 49;
    localparam int DEN_W = 34;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // ln(2) in Q32 and the argument above which e^-u reads as zero.
    localparam logic [35:0] LN2_Q32    = 36'd2977044472;
    localparam logic [50:0] EXP_CUTOFF = 51'd851968;
    localparam logic [3:0]  EXP_K_LAST = 4'd12;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_Y      = 2'd2,
        ACT_EVAL   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KT_LINEAR  = 2'd0,
        KT_POLY    = 2'd1,
        KT_RBF     = 2'd2,
        KT_SIGMOID = 2'd3
    } t_kernel;

    typedef enum logic [1:0] {
        CFG_KERNEL_TYPE = 2'd0,
        CFG_POLY_DEGREE = 2'd1,
        CFG_GAMMA_SCALE = 2'd2,
        CFG_OFFSET_COEF = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_APPEND,
        OP_LATCH,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_XY,
        OP_ADD_DIST,
        OP_ADD_DIST_ADV,
        OP_ADD_BOTH_ADV,
        OP_GMUL,
        OP_GSUM,
        OP_LINEAR,
        OP_POLY_ONE,
        OP_POLY_SAT,
        OP_POLY_INIT,
        OP_POLY_MUL,
        OP_POLY_FIX,
        OP_POLY_RES,
        OP_EXP_INIT,
        OP_EXP_RED,
        OP_EXP_FIRST,
        OP_EXP_MUL,
        OP_DIV_K,
        OP_DIV_TANH,
        OP_DIV_STEP,
        OP_EXP_ACC,
        OP_EXP_FIN,
        OP_RBF,
        OP_TANH,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MRG_RD,
        S_MRG_CMP,
        S_MRG_ACC_X,
        S_MRG_ACC_XY,
        S_MRG_ACC_Y,
        S_DRN_RD,
        S_DRN_SQ,
        S_DRN_ACC,
        S_G_MUL,
        S_G_SUM,
        S_DISPATCH,
        S_POLY_CHK,
        S_POLY_FIX,
        S_EXP_RED,
        S_EXP_MUL,
        S_EXP_DIVS,
        S_EXP_DIVW,
        S_EXP_FIN,
        S_FINAL,
        S_TANH_W,
        S_OUT
    } t_state;

    typedef struct packed {
        t_kernel ktype;
        logic    ptr_lt_cnt;
        logic    x_lt_y;
        logic    x_eq_y;
        logic    deg_zero;
        logic    a_in_range;
        logic    poly_more;
        logic    exp_zero;
        logic    rem_ge_ln2;
        logic    k_last;
        logic    div_done;
        logic    out_free;
    } t_status;

endpackage

// ===== hw/rtl/sske_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one command word with its feature index and value.
interface sske_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [15:0]       feature_index;
    logic signed [15:0] feature_value;

    modport source (output valid, action, feature_index, feature_value, input ready);
    modport sink   (input valid, action, feature_index, feature_value, output ready);
endinterface

// ===== hw/rtl/sske_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: one kernel value word with its overflow flag.
interface sske_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] kernel_value;
    logic               overflow_flag;

    modport source (output valid, kernel_value, overflow_flag, input ready);
    modport sink   (input valid, kernel_value, overflow_flag, output ready);
endinterface

// ===== hw/rtl/sske_dp.sv =====
`timescale 1ns / 1ps
// Datapath: x store, accumulators, kernel arithmetic, divider and result register.
module sske_dp #(
    parameter int VECTOR_DEPTH = sske_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sske_pkg::t_op                     i_op,
    output sske_pkg::t_status                 o_status,
    input  logic                              i_cfg_we,
    input  logic [sske_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sske_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [15:0]                       i_feature_index,
    input  logic signed [15:0]                i_feature_value,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [31:0]                o_kernel_value,
    output logic                              o_overflow_flag
);
    import sske_pkg::*;

    localparam int AW = $clog2(VECTOR_DEPTH);
    localparam int CW = $clog2(VECTOR_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(VECTOR_DEPTH);

    function automatic logic fits32(input logic signed [49:0] v);
        return v[49:31] == {19{v[49]}};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] s;
        if (fits32(v)) begin
            s = v[31:0];
        end else begin
            s = v[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s;
    endfunction

    // Configuration
    t_kernel            r_ktype;
    logic [3:0]         r_deg;
    logic [23:0]        r_gamma;
    logic signed [31:0] r_coef;

    // x store: feature index in the upper half, value in the lower half.
    logic [31:0]        r_mem [VECTOR_DEPTH];
    logic [31:0]        r_rd;

    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_ptr;
    logic signed [47:0] r_dot;
    logic [46:0]        r_dist;
    logic               r_dropped;
    logic               r_asat;
    logic               r_sat;

    logic [15:0]        r_y_idx;
    logic signed [15:0] r_y_val;
    logic signed [31:0] r_prod;
    logic [31:0]        r_sq;

    logic signed [48:0] r_ghi;
    logic [47:0]        r_glo;
    logic signed [49:0] r_a;

    logic signed [31:0] r_pr;
    logic signed [63:0] r_pprod;
    logic [3:0]         r_pk;

    logic [35:0]        r_rem;
    logic [4:0]         r_n;
    logic               r_ezero;
    logic               r_neg;
    logic [31:0]        r_er;
    logic [31:0]        r_term;
    logic [33:0]        r_sum;
    logic [63:0]        r_eprod;
    logic [3:0]         r_ek;
    logic [32:0]        r_e;

    logic [DEN_W-1:0]     r_dv_rem;
    logic [DIV_W-1:0]     r_dv_quo;
    logic [DEN_W-1:0]     r_dv_den;
    logic [DIV_CNT_W-1:0] r_dv_cnt;

    logic signed [31:0] r_res;
    logic               r_out_valid;
    logic signed [31:0] r_out_val;
    logic               r_out_flag;

    // Combinational helpers
    logic [15:0]        w_x_idx;
    logic signed [15:0] w_x_val;
    logic signed [16:0] w_d;
    logic signed [33:0] w_sq_full;
    logic signed [31:0] w_xy;
    logic signed [48:0] w_dot_sum;
    logic [47:0]        w_dist_sum;
    logic signed [23:0] w_hi;
    logic [23:0]        w_lo;
    logic signed [48:0] w_g_hi;
    logic [47:0]        w_g_lo;
    logic signed [49:0] w_coef_add;
    logic signed [49:0] w_gsum;
    logic signed [49:0] w_mag;
    logic [50:0]        w_arg;
    logic [34:0]        w_shift;
    logic               w_qbit;
    logic [33:0]        w_half;
    logic [33:0]        w_round;
    logic [33:0]        w_rbf;
    logic [33:0]        w_den;
    logic [32:0]        w_numb;
    logic [48:0]        w_num;
    logic [31:0]        w_q;

    always_comb begin
        w_x_idx = r_rd[31:16];
        w_x_val = r_rd[15:0];
        unique case (i_op)
            OP_SQ_X:  w_d = 17'(w_x_val);
            OP_SQ_XY: w_d = 17'(w_x_val) - 17'(r_y_val);
            default:  w_d = 17'(r_y_val);
        endcase
        w_sq_full = w_d * w_d;
        w_xy      = w_x_val * r_y_val;

        w_dot_sum  = 49'(r_dot) + 49'(r_prod);
        w_dist_sum = {1'b0, r_dist} + 48'(r_sq);

        if (r_ktype == KT_RBF) begin
            w_hi = $signed({1'b0, r_dist[46:24]});
            w_lo = r_dist[23:0];
            w_coef_add = '0;
        end else begin
            w_hi = r_dot[47:24];
            w_lo = r_dot[23:0];
            w_coef_add = 50'(r_coef);
        end
        w_g_hi = $signed({1'b0, r_gamma}) * w_hi;
        w_g_lo = r_gamma * w_lo;
        w_gsum = 50'(r_ghi) + $signed({26'b0, r_glo[47:24]}) + w_coef_add;

        w_mag = r_a[49] ? -r_a : r_a;
        w_arg = (r_ktype == KT_RBF) ? 51'(r_a) : {w_mag, 1'b0};

        w_shift = {r_dv_rem, r_dv_quo[DIV_W-1]};
        w_qbit  = w_shift >= {1'b0, r_dv_den};

        w_half  = (34'd1 << r_n) >> 1;
        w_round = (r_sum + w_half) >> r_n;
        w_rbf   = {1'b0, r_e} + 34'd32768;

        w_den  = 34'h1_0000_0000 + 34'(r_e);
        w_numb = 33'h1_0000_0000 - r_e;
        w_num  = {w_numb, 16'b0} + 49'(w_den >> 1);
        w_q    = 32'(r_dv_quo[16:0]);
    end

    // Store: written at the fill count, read at the merge pointer every cycle.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_APPEND && r_cnt < DEPTH_C) begin
            r_mem[r_cnt[AW-1:0]] <= {i_feature_index, i_feature_value};
        end
        r_rd <= r_mem[r_ptr[AW-1:0]];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ktype <= KT_RBF;
            r_deg   <= 4'd3;
            r_gamma <= 24'd65536;
            r_coef  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KERNEL_TYPE: r_ktype <= t_kernel'(i_cfg_data[1:0]);
                CFG_POLY_DEGREE: r_deg   <= i_cfg_data[3:0];
                CFG_GAMMA_SCALE: r_gamma <= i_cfg_data[23:0];
                CFG_OFFSET_COEF: r_coef  <= i_cfg_data;
            endcase
        end
    end

    // Control state of the vector and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_ptr     <= '0;
            r_dot     <= '0;
            r_dist    <= '0;
            r_dropped <= 1'b0;
            r_asat    <= 1'b0;
            r_sat     <= 1'b0;
            r_out_valid <= 1'b0;
            r_dv_cnt  <= '0;
        end else begin
            if (i_op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (i_op)
                OP_CLEAR: begin
                    r_cnt     <= '0;
                    r_ptr     <= '0;
                    r_dot     <= '0;
                    r_dist    <= '0;
                    r_dropped <= 1'b0;
                    r_asat    <= 1'b0;
                end
                OP_APPEND: begin
                    if (r_cnt < DEPTH_C) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_dropped <= 1'b1;
                    end
                end
                OP_LATCH: r_sat <= 1'b0;
                OP_ADD_DIST, OP_ADD_DIST_ADV, OP_ADD_BOTH_ADV: begin
                    if (w_dist_sum[47]) begin
                        r_dist <= '1;
                        r_asat <= 1'b1;
                    end else begin
                        r_dist <= w_dist_sum[46:0];
                    end
                    if (i_op == OP_ADD_BOTH_ADV) begin
                        if (w_dot_sum[48] != w_dot_sum[47]) begin
                            r_dot  <= {w_dot_sum[48], {47{~w_dot_sum[48]}}};
                            r_asat <= 1'b1;
                        end else begin
                            r_dot <= w_dot_sum[47:0];
                        end
                    end
                    if (i_op != OP_ADD_DIST) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                OP_LINEAR: begin
                    if (!fits32(50'(r_dot >>> 8))) r_sat <= 1'b1;
                end
                OP_POLY_SAT: r_sat <= 1'b1;
                OP_POLY_FIX: begin
                    if (!fits32(50'(r_pprod >>> 16))) r_sat <= 1'b1;
                end
                OP_DIV_K, OP_DIV_TANH: r_dv_cnt <= DIV_CNT_W'(DIV_W);
                OP_DIV_STEP: r_dv_cnt <= r_dv_cnt - 1'b1;
                OP_OUT: begin
                    r_ptr  <= '0;
                    r_dot  <= '0;
                    r_dist <= '0;
                    r_asat <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Arithmetic payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LATCH: begin
                r_y_idx <= i_feature_index;
                r_y_val <= i_feature_value;
            end
            OP_SQ_X, OP_SQ_Y, OP_SQ_XY: begin
                r_sq   <= w_sq_full[31:0];
                r_prod <= w_xy;
            end
            OP_GMUL: begin
                r_ghi <= w_g_hi;
                r_glo <= w_g_lo;
            end
            OP_GSUM:     r_a   <= w_gsum;
            OP_LINEAR:   r_res <= sat32(50'(r_dot >>> 8));
            OP_POLY_ONE: r_res <= 32'sd65536;
            OP_POLY_SAT: r_res <= (r_a[49] && r_deg[0]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            OP_POLY_INIT: begin
                r_pr <= r_a[31:0];
                r_pk <= 4'd1;
            end
            OP_POLY_MUL: r_pprod <= r_pr * $signed(r_a[31:0]);
            OP_POLY_FIX: begin
                r_pr <= sat32(50'(r_pprod >>> 16));
                r_pk <= r_pk + 1'b1;
            end
            OP_POLY_RES: r_res <= r_pr;
            OP_EXP_INIT: begin
                r_ezero <= w_arg >= EXP_CUTOFF;
                r_rem   <= {w_arg[19:0], 16'b0};
                r_n     <= '0;
                r_neg   <= r_a[49];
            end
            OP_EXP_RED: begin
                r_rem <= r_rem - LN2_Q32;
                r_n   <= r_n + 1'b1;
            end
            OP_EXP_FIRST: begin
                // First series term is the reduced argument itself.
                r_er   <= r_rem[31:0];
                r_term <= r_rem[31:0];
                r_sum  <= 34'h1_0000_0000 - 34'(r_rem[31:0]);
                r_ek   <= 4'd2;
            end
            OP_EXP_MUL: r_eprod <= r_term * r_er;
            OP_DIV_K: begin
                r_dv_quo <= DIV_W'(r_eprod[63:32]);
                r_dv_den <= DEN_W'(r_ek);
                r_dv_rem <= '0;
            end
            OP_DIV_TANH: begin
                r_dv_quo <= w_num;
                r_dv_den <= w_den;
                r_dv_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_dv_rem <= w_qbit ? DEN_W'(w_shift - {1'b0, r_dv_den}) : w_shift[DEN_W-1:0];
                r_dv_quo <= {r_dv_quo[DIV_W-2:0], w_qbit};
            end
            OP_EXP_ACC: begin
                r_term <= r_dv_quo[31:0];
                r_sum  <= r_ek[0] ? r_sum - 34'(r_dv_quo[31:0])
                                  : r_sum + 34'(r_dv_quo[31:0]);
                r_ek   <= r_ek + 1'b1;
            end
            OP_EXP_FIN: r_e   <= r_ezero ? '0 : w_round[32:0];
            OP_RBF:     r_res <= 32'(w_rbf[33:16]);
            OP_TANH:    r_res <= r_neg ? -$signed(w_q) : $signed(w_q);
            OP_OUT: begin
                r_out_val  <= r_res;
                r_out_flag <= r_sat | r_asat | r_dropped;
            end
            default: ;
        endcase
    end

    assign o_status.ktype      = r_ktype;
    assign o_status.ptr_lt_cnt = r_ptr < r_cnt;
    assign o_status.x_lt_y     = w_x_idx < r_y_idx;
    assign o_status.x_eq_y     = w_x_idx == r_y_idx;
    assign o_status.deg_zero   = r_deg == 4'd0;
    assign o_status.a_in_range = fits32(r_a);
    assign o_status.poly_more  = r_pk < r_deg;
    assign o_status.exp_zero   = r_ezero;
    assign o_status.rem_ge_ln2 = r_rem >= LN2_Q32;
    assign o_status.k_last     = r_ek == EXP_K_LAST;
    assign o_status.div_done   = r_dv_cnt == '0;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_kernel_value  = r_out_val;
    assign o_overflow_flag = r_out_flag;

endmodule

// ===== hw/rtl/sske_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences merge, drain and kernel evaluation steps of the datapath.
module sske_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_action,
    output logic              o_in_ready,
    input  sske_pkg::t_status i_status,
    output sske_pkg::t_op     o_op
);
    import sske_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (t_action'(i_in_action))
                        ACT_CLEAR:  o_op = OP_CLEAR;
                        ACT_APPEND: o_op = OP_APPEND;
                        ACT_Y: begin
                            o_op    = OP_LATCH;
                            n_state = S_MRG_RD;
                        end
                        ACT_EVAL: begin
                            o_op    = OP_LATCH;
                            n_state = S_DRN_RD;
                        end
                    endcase
                end
            end
            S_MRG_RD: begin
                if (i_status.ptr_lt_cnt) begin
                    n_state = S_MRG_CMP;
                end else begin
                    o_op    = OP_SQ_Y;
                    n_state = S_MRG_ACC_Y;
                end
            end
            S_MRG_CMP: begin
                priority if (i_status.x_lt_y) begin
                    o_op    = OP_SQ_X;
                    n_state = S_MRG_ACC_X;
                end else if (i_status.x_eq_y) begin
                    o_op    = OP_SQ_XY;
                    n_state = S_MRG_ACC_XY;
                end else begin
                    o_op    = OP_SQ_Y;
                    n_state = S_MRG_ACC_Y;
                end
            end
            S_MRG_ACC_X: begin
                o_op    = OP_ADD_DIST_ADV;
                n_state = S_MRG_RD;
            end
            S_MRG_ACC_XY: begin
                o_op    = OP_ADD_BOTH_ADV;
                n_state = S_IDLE;
            end
            S_MRG_ACC_Y: begin
                o_op    = OP_ADD_DIST;
                n_state = S_IDLE;
            end
            S_DRN_RD: begin
                n_state = i_status.ptr_lt_cnt ? S_DRN_SQ : S_G_MUL;
            end
            S_DRN_SQ: begin
                o_op    = OP_SQ_X;
                n_state = S_DRN_ACC;
            end
            S_DRN_ACC: begin
                o_op    = OP_ADD_DIST_ADV;
                n_state = S_DRN_RD;
            end
            S_G_MUL: begin
                o_op    = OP_GMUL;
                n_state = S_G_SUM;
            end
            S_G_SUM: begin
                o_op    = OP_GSUM;
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_status.ktype)
                    KT_LINEAR: begin
                        o_op    = OP_LINEAR;
                        n_state = S_OUT;
                    end
                    KT_POLY: begin
                        priority if (i_status.deg_zero) begin
                            o_op    = OP_POLY_ONE;
                            n_state = S_OUT;
                        end else if (!i_status.a_in_range) begin
                            o_op    = OP_POLY_SAT;
                            n_state = S_OUT;
                        end else begin
                            o_op    = OP_POLY_INIT;
                            n_state = S_POLY_CHK;
                        end
                    end
                    KT_RBF, KT_SIGMOID: begin
                        o_op    = OP_EXP_INIT;
                        n_state = S_EXP_RED;
                    end
                endcase
            end
            S_POLY_CHK: begin
                if (i_status.poly_more) begin
                    o_op    = OP_POLY_MUL;
                    n_state = S_POLY_FIX;
                end else begin
                    o_op    = OP_POLY_RES;
                    n_state = S_OUT;
                end
            end
            S_POLY_FIX: begin
                o_op    = OP_POLY_FIX;
                n_state = S_POLY_CHK;
            end
            S_EXP_RED: begin
                priority if (i_status.exp_zero) begin
                    n_state = S_EXP_FIN;
                end else if (i_status.rem_ge_ln2) begin
                    o_op = OP_EXP_RED;
                end else begin
                    o_op    = OP_EXP_FIRST;
                    n_state = S_EXP_MUL;
                end
            end
            S_EXP_MUL: begin
                o_op    = OP_EXP_MUL;
                n_state = S_EXP_DIVS;
            end
            S_EXP_DIVS: begin
                o_op    = OP_DIV_K;
                n_state = S_EXP_DIVW;
            end
            S_EXP_DIVW: begin
                if (i_status.div_done) begin
                    o_op    = OP_EXP_ACC;
                    n_state = i_status.k_last ? S_EXP_FIN : S_EXP_MUL;
                end else begin
                    o_op = OP_DIV_STEP;
                end
            end
            S_EXP_FIN: begin
                o_op    = OP_EXP_FIN;
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (i_status.ktype == KT_RBF) begin
                    o_op    = OP_RBF;
                    n_state = S_OUT;
                end else begin
                    o_op    = OP_DIV_TANH;
                    n_state = S_TANH_W;
                end
            end
            S_TANH_W: begin
                if (i_status.div_done) begin
                    o_op    = OP_TANH;
                    n_state = S_OUT;
                end else begin
                    o_op = OP_DIV_STEP;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/sparse_svm_kernel_eval.sv =====
`timescale 1ns / 1ps
// Top level of the sparse SVM kernel evaluator: controller, datapath and ports.
//
// Usage: the input channel carries command words (clear x, append x element,
// y element, evaluate). x is appended in ascending index order into an on-chip
// store of VECTOR_DEPTH entries; appends past capacity are dropped and flagged.
// y elements are then sent in ascending order and merged against x, summing
// the dot product and squared distance. An evaluate word drains the remaining
// x terms and produces one result word on the output channel: linear,
// polynomial, radial basis or sigmoid kernel in signed Q16.16.
// Steps: clear and append are done in the idle state. A y element reads,
// compares and accumulates each x entry that it passes. Evaluate squares and
// accumulates each undrained x entry; polynomial then takes a multiply and a
// fix step for each degree above one, and radial basis range-reduces and adds
// 11 series terms after the first, each through the 49-step shared restoring
// divider; sigmoid adds one more division. One word is in work at a time.
// Reset clears the store's fill count, pointer, accumulators and flags and
// loads the register defaults. The result sits in an output register: while
// the receiver stalls, new words are still taken until the next evaluate is
// ready to deliver, which then waits for the register to drain.
module sparse_svm_kernel_eval #(
    parameter int VECTOR_DEPTH = sske_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sske_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sske_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sske_in_if.sink                         i_in,
    sske_out_if.source                      o_res
);
    import sske_pkg::*;

    t_op     w_op;
    t_status w_status;

    sske_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .i_status    (w_status),
        .o_op        (w_op)
    );

    sske_dp #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_op),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_feature_index (i_in.feature_index),
        .i_feature_value (i_in.feature_value),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_kernel_value  (o_res.kernel_value),
        .o_overflow_flag (o_res.overflow_flag)
    );

endmodule
